>>> rtl/lif_pkg.sv
// Shared types and constants for the LIF neuron table.
// Holds the channel payload structs, config struct, table entry layout and
// the exp(-w) table. No dependencies.
package lif_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned PADDR_W = 5;

    // register indexes (paddr[4:2])
    localparam logic [2:0] REG_INV_CAP    = 3'd0;
    localparam logic [2:0] REG_INV_TAU    = 3'd1;
    localparam logic [2:0] REG_V_REST     = 3'd2;
    localparam logic [2:0] REG_V_RESET    = 3'd3;
    localparam logic [2:0] REG_FIRE_LEVEL = 3'd4;
    localparam logic [2:0] REG_REFRACT    = 3'd5;

    localparam logic CMD_CHARGE = 1'b0;
    localparam logic CMD_DECAY  = 1'b1;

    localparam logic [24:0] ONE_Q24 = 25'h100_0000;

    // exp(-w) in Q0.24 for w = 16, 8, 4, 2, 1, 1/2 .. 1/256
    localparam logic [23:0] EXP_TAB [13] = '{
        24'd2, 24'd5628, 24'd307285, 24'd2270549, 24'd6171993,
        24'd10175896, 24'd13066109, 24'd14805841, 24'd15760736,
        24'd16261035, 24'd16517109, 24'd16646655, 24'd16711808
    };
    localparam logic [3:0] EXP_LAST = 4'd12;

    typedef struct packed {
        logic               cmd;
        logic [9:0]         neuron;
        logic [10:0]        count;
        logic [31:0]        time_now;
        logic signed [23:0] charge;
    } t_in;

    typedef struct packed {
        logic       spiked;
        logic [9:0] neuron_out;
    } t_out;

    typedef struct packed {
        logic [23:0] inv_capacitance;
        logic [23:0] inv_tau;
        logic [23:0] v_rest;
        logic [23:0] v_reset;
        logic [23:0] fire_level;
        logic [15:0] refractory_ticks;
    } t_cfg;

    typedef struct packed {
        logic [23:0] v;
        logic [31:0] ls;
        logic [31:0] lu;
        logic        hf;
    } t_entry;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_CHARGE,
        ST_XPROD,
        ST_EXP,
        ST_EXPW,
        ST_FRAC,
        ST_FRACW,
        ST_VOLT,
        ST_VOLTW,
        ST_ADV,
        ST_DONE
    } t_state;

endpackage

>>> rtl/lif_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lif_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/lif_mul.sv
// Shared 32x25 unsigned multiplier with a registered product.
// No dependencies.
module lif_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [24:0] i_b,
    output logic [56:0] o_p
);

    logic [56:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= 57'(i_a) * 57'(i_b);
    end

    assign o_p = r_p;

endmodule

>>> rtl/lif_cfg.sv
// APB-style configuration registers for the LIF neuron table.
// Depends on lif_pkg.
module lif_cfg
    import lif_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg r_cfg;
    logic [2:0] idx;

    assign idx = paddr[4:2];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.inv_capacitance  <= 24'd65536;
            r_cfg.inv_tau          <= 24'd1048576;
            r_cfg.v_rest           <= 24'd0;
            r_cfg.v_reset          <= 24'd0;
            r_cfg.fire_level       <= 24'd65536;
            r_cfg.refractory_ticks <= 16'd2;
        end else if (psel && penable && pwrite) begin
            unique case (idx)
                REG_INV_CAP:    r_cfg.inv_capacitance  <= pwdata[23:0];
                REG_INV_TAU:    r_cfg.inv_tau          <= pwdata[23:0];
                REG_V_REST:     r_cfg.v_rest           <= pwdata[23:0];
                REG_V_RESET:    r_cfg.v_reset          <= pwdata[23:0];
                REG_FIRE_LEVEL: r_cfg.fire_level       <= pwdata[23:0];
                REG_REFRACT:    r_cfg.refractory_ticks <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_INV_CAP:    prdata = {8'd0, r_cfg.inv_capacitance};
            REG_INV_TAU:    prdata = {8'd0, r_cfg.inv_tau};
            REG_V_REST:     prdata = {8'd0, r_cfg.v_rest};
            REG_V_RESET:    prdata = {8'd0, r_cfg.v_reset};
            REG_FIRE_LEVEL: prdata = {8'd0, r_cfg.fire_level};
            REG_REFRACT:    prdata = {16'd0, r_cfg.refractory_ticks};
            default:        prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/lif_neuron_table_update_top.sv
// Leaky integrate-and-fire neuron table: one packed RAM entry per neuron
// (voltage, last spike, last update, fired bit), a sequencer and one shared
// multiplier. Takes one command at a time and returns one result per command.
// After reset a clearing pass zeroes all NEURONS entries, with input stalled.
// A charge command steps through accept, RAM read, check and multiply, write
// and result (a refractory neuron skips the write); the next command is
// accepted once the output register is free. A decay sweep reads and checks
// each neuron, resets it to v_reset if refractory, goes straight to the voltage
// product if dt*inv_tau reaches 32, else steps through the 13 exponent bits
// of dt*inv_tau with a multiply per set bit, then the fraction and voltage
// products; every product goes through the single shared multiplier.
// Depends on lif_pkg, lif_cfg, lif_mul, lif_ram.
module lif_neuron_table_update_top
    import lif_pkg::*;
#(
    parameter int unsigned NEURONS = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in                i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out               o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    localparam int unsigned AW = (NEURONS > 1) ? $clog2(NEURONS) : 1;
    localparam logic [16:0] NLIM = 17'(NEURONS);
    localparam logic [AW-1:0] CLR_LAST = AW'(NEURONS - 1);
    localparam int unsigned EW = $bits(t_entry);

    t_cfg cfg;

    lif_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    t_state r_state, n_state;

    logic               r_cmd;
    logic [9:0]         r_first;
    logic [31:0]        r_now;
    logic signed [23:0] r_chg;
    // covers first neuron plus the largest count field
    logic [11:0]        r_idx;
    logic [10:0]        r_left;
    t_entry             r_ent;
    logic [12:0]        r_bits;
    logic [3:0]         r_k;
    logic [15:0]        r_frac;
    logic [24:0]        r_f;
    logic               r_neg;
    logic               r_spk;
    logic [AW-1:0]      r_clr;
    logic               r_ovalid;
    t_out               r_odata;

    // RAM and multiplier
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    t_entry        ram_wdata;
    t_entry        ram_rdata;
    logic [EW-1:0] ram_rbits;
    logic [31:0]   mul_a;
    logic [24:0]   mul_b;
    logic [56:0]   mul_p;

    lif_ram #(
        .WIDTH (EW),
        .DEPTH (NEURONS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (AW'(r_idx)),
        .o_rdata (ram_rbits)
    );

    assign ram_rdata = t_entry'(ram_rbits);

    lif_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // datapath
    logic               accept;
    logic               out_free;
    logic               refr;
    logic [31:0]        dt;
    logic [24:0]        chg_mag;
    logic [31:0]        q_chg;
    logic signed [33:0] sum;
    logic signed [33:0] thr;
    logic               fire;
    logic [23:0]        v_sat;
    logic signed [24:0] diff;
    logic [24:0]        diff_mag;
    logic [24:0]        f_rnd;
    logic [25:0]        q_dec;
    logic signed [25:0] v_dec;
    logic               big_x;
    logic [11:0]        idx_inc;
    logic [10:0]        left_dec;
    logic               sweep_end;
    logic               first_out;

    assign out_free  = !r_ovalid || !i_out_stall;
    assign accept    = i_in_valid && (r_state == ST_IDLE);
    assign refr      = ram_rdata.hf
                       && ((r_now - ram_rdata.ls) < {16'd0, cfg.refractory_ticks});
    assign dt        = r_now - ram_rdata.lu;
    assign chg_mag   = r_chg[23] ? 25'(-{r_chg[23], r_chg}) : {1'b0, r_chg};
    assign q_chg     = 32'((mul_p + 57'd32768) >> 16);
    assign sum       = {{10{r_ent.v[23]}}, r_ent.v}
                       + (r_neg ? -$signed({2'b00, q_chg}) : $signed({2'b00, q_chg}));
    assign thr       = {{10{cfg.fire_level[23]}}, cfg.fire_level};
    assign fire      = (sum >= thr);
    assign v_sat     = (sum > 34'sd8388607)  ? 24'h7F_FFFF :
                       (sum < -34'sd8388608) ? 24'h80_0000 : sum[23:0];
    assign diff      = {r_ent.v[23], r_ent.v} - {cfg.v_rest[23], cfg.v_rest};
    assign diff_mag  = diff[24] ? 25'(-diff) : 25'(diff);
    assign f_rnd     = 25'((mul_p + 57'h80_0000) >> 24);
    assign q_dec     = 26'((mul_p + 57'h80_0000) >> 24);
    assign v_dec     = {{2{cfg.v_rest[23]}}, cfg.v_rest}
                       + (r_neg ? -$signed(q_dec) : $signed(q_dec));
    assign big_x     = (mul_p[56:29] != '0);
    assign idx_inc   = r_idx + 12'd1;
    assign left_dec  = r_left - 11'd1;
    assign sweep_end = (left_dec == '0) || ({5'd0, idx_inc} >= NLIM);
    assign first_out = ({7'd0, i_in_data.neuron} >= NLIM);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:  if (r_clr == CLR_LAST) n_state = ST_IDLE;
            ST_IDLE: begin
                if (accept) begin
                    if (first_out || (i_in_data.cmd == CMD_DECAY
                                      && i_in_data.count == '0)) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ:   n_state = ST_CHECK;
            ST_CHECK: begin
                if (r_cmd == CMD_CHARGE) n_state = refr ? ST_DONE : ST_CHARGE;
                else                     n_state = refr ? ST_ADV : ST_XPROD;
            end
            ST_CHARGE: n_state = ST_DONE;
            ST_XPROD:  n_state = big_x ? ST_VOLT : ST_EXP;
            ST_EXP: begin
                if (r_bits[12])            n_state = ST_EXPW;
                else if (r_k == EXP_LAST)  n_state = ST_FRAC;
            end
            ST_EXPW:   n_state = (r_k == EXP_LAST) ? ST_FRAC : ST_EXP;
            ST_FRAC:   n_state = ST_FRACW;
            ST_FRACW:  n_state = ST_VOLT;
            ST_VOLT:   n_state = ST_VOLTW;
            ST_VOLTW:  n_state = ST_ADV;
            ST_ADV:    n_state = sweep_end ? ST_DONE : ST_READ;
            ST_DONE:   if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // RAM write and multiplier operands
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = AW'(r_idx);
        ram_wdata = r_ent;
        mul_a     = 32'(r_f);
        mul_b     = 25'(EXP_TAB[r_k]);
        unique case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
            end
            ST_CHECK: begin
                if (r_cmd == CMD_CHARGE) begin
                    mul_a = 32'(chg_mag);
                    mul_b = {1'b0, cfg.inv_capacitance};
                end else begin
                    mul_a = dt;
                    mul_b = {1'b0, cfg.inv_tau};
                    if (refr) begin
                        ram_we      = 1'b1;
                        ram_wdata   = ram_rdata;
                        ram_wdata.v = cfg.v_reset;
                    end
                end
            end
            ST_CHARGE: begin
                ram_we = 1'b1;
                if (fire) begin
                    ram_wdata.v  = cfg.v_reset;
                    ram_wdata.ls = r_now;
                    ram_wdata.hf = 1'b1;
                end else begin
                    ram_wdata.v = v_sat;
                end
            end
            ST_FRAC: mul_b = ONE_Q24 - {9'd0, r_frac};
            ST_VOLT: begin
                mul_a = 32'(diff_mag);
                mul_b = r_f;
            end
            ST_VOLTW: begin
                ram_we       = 1'b1;
                ram_wdata.v  = v_dec[23:0];
                ram_wdata.lu = r_now;
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr <= r_clr + AW'(1);
            if (r_state == ST_DONE && out_free) r_ovalid <= 1'b1;
            else if (!i_out_stall)              r_ovalid <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    r_cmd   <= i_in_data.cmd;
                    r_first <= i_in_data.neuron;
                    r_now   <= i_in_data.time_now;
                    r_chg   <= i_in_data.charge;
                    r_idx   <= {2'b00, i_in_data.neuron};
                    r_left  <= i_in_data.count;
                    r_spk   <= 1'b0;
                end
            end
            ST_CHECK: begin
                r_ent <= ram_rdata;
                r_neg <= r_chg[23];
            end
            ST_CHARGE: r_spk <= fire;
            ST_XPROD: begin
                r_f    <= big_x ? 25'd0 : ONE_Q24;
                r_bits <= mul_p[28:16];
                r_frac <= mul_p[15:0];
                r_k    <= '0;
            end
            ST_EXP: begin
                if (!r_bits[12]) begin
                    r_bits <= r_bits << 1;
                    r_k    <= r_k + 4'd1;
                end
            end
            ST_EXPW: begin
                r_f    <= f_rnd;
                r_bits <= r_bits << 1;
                r_k    <= r_k + 4'd1;
            end
            ST_FRACW: r_f <= f_rnd;
            ST_VOLT:  r_neg <= diff[24];
            ST_ADV: begin
                r_idx  <= idx_inc;
                r_left <= left_dec;
            end
            ST_DONE: begin
                if (out_free) begin
                    r_odata.spiked     <= r_spk;
                    r_odata.neuron_out <= r_first;
                end
            end
            default: ;
        endcase
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

`ifndef SYNTHESIS
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE || r_state == ST_DONE) |-> !ram_we)
        else $error("table written outside a transaction");
    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && r_state != ST_CLEAR) |-> ({5'd0, r_idx} < NLIM))
        else $error("table write beyond neuron range");
    a_exp_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXP || r_state == ST_EXPW) |-> (r_k <= EXP_LAST))
        else $error("exponent step count overrun");
    a_decay_no_spike: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_cmd == CMD_DECAY) |-> !r_spk)
        else $error("decay sweep reported a spike");
`endif

endmodule

>>> sim/tb_lif_neuron_table_update_top.sv
// Testbench for lif_neuron_table_update_top: drives charge and decay transactions,
// predicts spike results from a shadow neuron table and compares every result.
// Depends on lif_pkg and the RTL of lif_neuron_table_update_top.
`timescale 1ns / 1ps

module tb_lif_neuron_table_update_top;
    import lif_pkg::*;

    localparam int unsigned N_NEURONS = 1024;
    localparam logic [2:0] REG_UNUSED = 3'd7;
    // allows a worst-case full sweep plus the clearing pass and small stalls
    localparam int unsigned IDLE_LIMIT = 200000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    t_in                i_in_data;
    logic               o_out_valid;
    logic               i_out_stall;
    t_out               o_out_data;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    lif_neuron_table_update_top #(.NEURONS(N_NEURONS)) dut (.*);

    // shadow configuration and neuron table
    logic [23:0]        inv_cap_q, inv_tau_q;
    logic signed [23:0] v_rest_q, v_reset_q, fire_level_q;
    logic [15:0]        refract_q;
    logic signed [23:0] volt_tbl [N_NEURONS];
    logic [31:0]        spike_tbl [N_NEURONS];
    logic [31:0]        upd_tbl [N_NEURONS];
    logic               fired_tbl [N_NEURONS];

    t_out        pending_results [$];
    int          errors = 0;
    int          n_charge = 0, n_spike = 0, n_decay = 0, n_swept = 0;
    bit          steady = 0;
    int          out_hold = 0;
    int          idle_cycles = 0;
    logic [31:0] tick;

    always #4 i_clk = ~i_clk;

    // round(a * b / 2^sh), half away from zero
    function automatic logic signed [63:0] scale_round(logic signed [63:0] a,
                                                        logic [63:0] b, int sh);
        logic        neg;
        logic [63:0] mag, p;
        neg = a < 0;
        mag = neg ? -a : a;
        p = (mag * b + (64'd1 << (sh - 1))) >> sh;
        return neg ? -$signed(p) : $signed(p);
    endfunction

    function automatic logic [63:0] leak_factor(logic [31:0] dt);
        logic [63:0] x, f;
        x = {32'd0, dt} * {40'd0, inv_tau_q};
        if (x >= (64'd32 << 24)) return 64'd0;
        f = 64'd1 << 24;
        for (int k = 0; k < 13; k++)
            if (x[28-k]) f = (f * EXP_TAB[k] + 64'h80_0000) >> 24;
        f = (f * ((64'd1 << 24) - x[15:0]) + 64'h80_0000) >> 24;
        return f;
    endfunction

    function automatic bit refractory(int idx, logic [31:0] now);
        logic [31:0] dt;
        dt = now - spike_tbl[idx];
        return fired_tbl[idx] && (dt < {16'd0, refract_q});
    endfunction

    task automatic predict_transaction(t_in it);
        t_out               res;
        logic signed [63:0] sum, rest, thr;
        int                 idx;
        res.spiked = 1'b0;
        res.neuron_out = it.neuron;
        rest = v_rest_q;
        thr = fire_level_q;
        if (it.cmd == CMD_CHARGE) begin
            n_charge++;
            idx = it.neuron;
            if (!refractory(idx, it.time_now)) begin
                sum = volt_tbl[idx] + scale_round(it.charge, {40'd0, inv_cap_q}, 16);
                if (sum >= thr) begin
                    volt_tbl[idx] = v_reset_q;
                    spike_tbl[idx] = it.time_now;
                    fired_tbl[idx] = 1'b1;
                    res.spiked = 1'b1;
                    n_spike++;
                end else begin
                    if (sum > 64'sd8388607) sum = 64'sd8388607;
                    if (sum < -64'sd8388608) sum = -64'sd8388608;
                    volt_tbl[idx] = sum[23:0];
                end
            end
        end else begin
            n_decay++;
            for (int i = 0; i < it.count; i++) begin
                idx = it.neuron + i;
                if (idx >= N_NEURONS) break;
                n_swept++;
                if (refractory(idx, it.time_now)) begin
                    volt_tbl[idx] = v_reset_q;
                end else begin
                    sum = rest + scale_round(volt_tbl[idx] - rest,
                                             leak_factor(it.time_now - upd_tbl[idx]), 24);
                    volt_tbl[idx] = sum[23:0];
                    upd_tbl[idx] = it.time_now;
                end
            end
        end
        pending_results.push_back(res);
    endtask

    // result side: sample at rising edge, stall drawn per transaction
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: neuron_out %0d", o_out_data.neuron_out);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.spiked !== want.spiked) begin
                    $error("spiked: expected %0b actual %0b", want.spiked, o_out_data.spiked);
                    errors++;
                end
                if (o_out_data.neuron_out !== want.neuron_out) begin
                    $error("neuron_out: expected %0d actual %0d",
                           want.neuron_out, o_out_data.neuron_out);
                    errors++;
                end
            end
            out_hold = steady ? 0 : $urandom_range(0, 15);
        end
    end

    always @(negedge i_clk) begin
        if (out_hold > 0) begin
            i_out_stall <= 1'b1;
            out_hold--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic send_transaction(t_in it);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 15);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (o_in_stall);
        predict_transaction(it);
    endtask

    // stop driving and wait until every expected result is back
    task automatic drain;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [2:0] idx, logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_INV_CAP:    inv_cap_q = value[23:0];
            REG_INV_TAU:    inv_tau_q = value[23:0];
            REG_V_REST:     v_rest_q = value[23:0];
            REG_V_RESET:    v_reset_q = value[23:0];
            REG_FIRE_LEVEL: fire_level_q = value[23:0];
            REG_REFRACT:    refract_q = value[15:0];
            default: ;
        endcase
    endtask

    task automatic load_config(logic [23:0] cap, logic [23:0] tau, logic [23:0] rest,
                               logic [23:0] vres, logic [23:0] thr, logic [15:0] refr);
        drain();
        reg_write(REG_INV_CAP, {8'd0, cap});
        reg_write(REG_INV_TAU, {8'd0, tau});
        reg_write(REG_V_REST, {8'd0, rest});
        reg_write(REG_V_RESET, {8'd0, vres});
        reg_write(REG_FIRE_LEVEL, {8'd0, thr});
        reg_write(REG_REFRACT, {16'd0, refr});
    endtask

    function automatic t_in make_item(logic cmd, int first, int cnt, logic [31:0] now,
                                      logic [23:0] chg);
        t_in it;
        it.cmd = cmd;
        it.neuron = 10'(first);
        it.count = 11'(cnt);
        it.time_now = now;
        it.charge = chg;
        return it;
    endfunction

    // mostly a small hot set of neurons with advancing time so spikes and
    // refractory windows happen; the rest is noise over the full field ranges
    function automatic t_in random_item();
        int          pick, first, cnt;
        logic [23:0] chg;
        pick = $urandom_range(0, 99);
        tick += ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1000) : $urandom_range(0, 3);
        first = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 15);
        chg = ($urandom_range(0, 7) == 0) ? 24'($urandom())
                                          : 24'($urandom_range(0, 24'h3_0000) - 24'h1_0000);
        if (pick < 65) return make_item(CMD_CHARGE, first, $urandom(), tick, chg);
        if (pick < 90) begin
            if (pick == 89)      cnt = 1024;
            else if (pick > 83)  cnt = $urandom_range(9, 64);
            else                 cnt = $urandom_range(1, 8);
            return make_item(CMD_DECAY, first, cnt, tick, 24'($urandom()));
        end
        return make_item(1'($urandom()), $urandom(), $urandom_range(0, 2047) & 11'h43F,
                         $urandom(), 24'($urandom()));
    endfunction

    task automatic run_random(int n);
        for (int i = 0; i < n; i++) send_transaction(random_item());
    endtask

    task automatic test_directed;
        steady = 1;
        // max charge fires at reset config, then a repeat inside refractory is ignored
        send_transaction(make_item(CMD_CHARGE, 0, 0, 32'd10, 24'h7F_FFFF));
        send_transaction(make_item(CMD_CHARGE, 0, 0, 32'd11, 24'h7F_FFFF));
        send_transaction(make_item(CMD_CHARGE, 0, 0, 32'd12, 24'h7F_FFFF));
        send_transaction(make_item(CMD_CHARGE, 1, 0, 32'd12, 24'h80_0000));
        send_transaction(make_item(CMD_CHARGE, 1, 0, 32'd12, 24'h80_0000));
        send_transaction(make_item(CMD_CHARGE, 2, 0, 32'd13, 24'h00_8000));
        send_transaction(make_item(CMD_CHARGE, 1023, 11'h7FF, 32'd13, 24'h00_FFFF));
        send_transaction(make_item(CMD_CHARGE, 1023, 0, 32'd13, 24'h00_0001));
        steady = 0;
        send_transaction(make_item(CMD_DECAY, 1, 1, 32'd20, 24'h0));
        send_transaction(make_item(CMD_DECAY, 0, 0, 32'd21, 24'h0));
        send_transaction(make_item(CMD_DECAY, 0, 4, 32'd13, 24'hFF_FFFF));
        send_transaction(make_item(CMD_DECAY, 1020, 11'h7FF, 32'd40, 24'h0));
        send_transaction(make_item(CMD_DECAY, 0, 1024, 32'd600, 24'h0));
        // time wraps past 2^32: difference taken modulo
        send_transaction(make_item(CMD_CHARGE, 3, 0, 32'hFFFF_FFFF, 24'h7F_FFFF));
        send_transaction(make_item(CMD_CHARGE, 3, 0, 32'd0, 24'h7F_FFFF));
        send_transaction(make_item(CMD_CHARGE, 2, 0, 32'hFFFF_FFF0, 24'h00_4000));
        send_transaction(make_item(CMD_DECAY, 2, 2, 32'd5, 24'h0));
        send_transaction(make_item(CMD_DECAY, 2, 1, 32'hFFFF_FFFF, 24'h0));
    endtask

    task automatic test_config_extremes;
        load_config(24'hFF_FFFF, 24'd0, 24'h80_0000, 24'h7F_FFFF, 24'h7F_FFFF, 16'hFFFF);
        reg_write(REG_UNUSED, 32'hFFFF_FFFF);
        tick = 32'd1000;
        run_random(30);
        load_config(24'd0, 24'hFF_FFFF, 24'h7F_FFFF, 24'h80_0000, 24'h80_0000, 16'd0);
        run_random(30);
    endtask

    task automatic test_random_phases;
        for (int ph = 0; ph < 4; ph++) begin
            load_config(24'($urandom_range(0, 24'h4_0000)),
                        24'($urandom_range(0, 24'h40_0000)),
                        24'(-$urandom_range(0, 24'h1_0000)),
                        24'(-$urandom_range(0, 24'h2_0000)),
                        24'($urandom_range(0, 24'h4_0000)),
                        16'($urandom_range(0, 10)));
            steady = (ph == 2);
            run_random(90);
        end
        steady = 0;
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        inv_cap_q = 24'd65536;
        inv_tau_q = 24'd1048576;
        v_rest_q = '0;
        v_reset_q = '0;
        fire_level_q = 24'sd65536;
        refract_q = 16'd2;
        tick = 32'd0;
        for (int i = 0; i < N_NEURONS; i++) begin
            volt_tbl[i] = '0;
            spike_tbl[i] = '0;
            upd_tbl[i] = '0;
            fired_tbl[i] = 1'b0;
        end
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_config_extremes();
        test_random_phases();
        drain();
        repeat (20) @(posedge i_clk);

        $display("covered %0d charge transactions (%0d spikes), %0d decay sweeps over %0d neurons",
                 n_charge, n_spike, n_decay, n_swept);
        $display("config phases: reset values, both register extremes, four random settings");
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
